[design/cartridge_mapper_with_tone_generator_top_defines.svh]
// Assertion macros used by the top-level design file.
`ifndef CARTRIDGE_MAPPER_WITH_TONE_GENERATOR_TOP_DEFINES_SVH
`define CARTRIDGE_MAPPER_WITH_TONE_GENERATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMTG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cmtg_pkg.sv]
`default_nettype none

package cmtg_pkg;

  // Bus item kinds.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_PPU   = 2'd3;

  // Result targets.
  localparam logic [2:0] TGT_OPEN = 3'd0;
  localparam logic [2:0] TGT_ROM  = 3'd1;
  localparam logic [2:0] TGT_RAM  = 3'd2;
  localparam logic [2:0] TGT_CHR  = 3'd3;
  localparam logic [2:0] TGT_NT   = 3'd4;
  localparam logic [2:0] TGT_NONE = 3'd5;

  // Register ports on the CPU bus.
  localparam logic [15:0] ADDR_BANK_SEL   = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA  = 16'ha000;
  localparam logic [15:0] ADDR_SOUND_SEL  = 16'hc000;
  localparam logic [15:0] ADDR_SOUND_DATA = 16'he000;

  // 8 KB CPU windows, by address bits 15..13.
  localparam logic [2:0] WIN_RAM   = 3'd3;
  localparam logic [2:0] WIN_PRG0  = 3'd4;
  localparam logic [2:0] WIN_PRG1  = 3'd5;
  localparam logic [2:0] WIN_PRG2  = 3'd6;
  localparam logic [7:0] FIXED_BANK = 8'h3f;

  // Indexed bank registers above the CHR and PRG banks.
  localparam logic [3:0] REG_MIRROR   = 4'd12;
  localparam logic [3:0] REG_IRQ_CTRL = 4'd13;
  localparam logic [3:0] REG_IRQ_LO   = 4'd14;
  localparam logic [3:0] REG_IRQ_HI   = 4'd15;

  // Mirroring modes.
  localparam logic [1:0] MIR_VERT   = 2'd0;
  localparam logic [1:0] MIR_HORZ   = 2'd1;
  localparam logic [1:0] MIR_SCR_LO = 2'd2;

  // Indexed sound registers.
  localparam logic [3:0] SND_PERIOD_LAST = 4'd5;
  localparam logic [3:0] SND_OFF         = 4'd7;
  localparam logic [3:0] SND_VOL_FIRST   = 4'd8;
  localparam logic [3:0] SND_VOL_LAST    = 4'd10;

  localparam int unsigned NUM_TONES = 3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  // Level to amplitude: 8192 / 2^((15-n)/2), truncated.
  function automatic logic [13:0] atten(input logic [3:0] level);
    logic [13:0] amp;
    case (level)
      4'd0:    amp = 14'd45;
      4'd1:    amp = 14'd64;
      4'd2:    amp = 14'd90;
      4'd3:    amp = 14'd128;
      4'd4:    amp = 14'd181;
      4'd5:    amp = 14'd256;
      4'd6:    amp = 14'd362;
      4'd7:    amp = 14'd512;
      4'd8:    amp = 14'd724;
      4'd9:    amp = 14'd1024;
      4'd10:   amp = 14'd1448;
      4'd11:   amp = 14'd2048;
      4'd12:   amp = 14'd2896;
      4'd13:   amp = 14'd4096;
      4'd14:   amp = 14'd5792;
      default: amp = 14'd8192;
    endcase
    return amp;
  endfunction

endpackage

`default_nettype wire

[design/cmtg_mapper.sv]
`default_nettype none

module cmtg_mapper
  import cmtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        op_valid,
  input  wire item_t       item,
  output logic [2:0]       target,
  output logic [18:0]      mapped_address,
  output logic             irq_next
);

  logic [3:0]  bank_select, bank_select_next;
  logic [7:0]  prg_bank [4];
  logic [7:0]  prg_bank_next [4];
  logic [7:0]  chr_bank [8];
  logic [7:0]  chr_bank_next [8];
  logic [1:0]  mirroring, mirroring_next;
  logic        irq_enabled, irq_enabled_next;
  logic        irq_counting, irq_counting_next;
  logic [15:0] irq_count, irq_count_next;
  logic        irq_level, irq_level_next;

  logic [15:0] irq_count_dec;
  logic [2:0]  win;
  logic [7:0]  bank;

  assign irq_count_dec = irq_count - 16'd1;
  assign win           = item.address[15:13];

  always_comb begin
    case (win)
      WIN_RAM:  bank = prg_bank[0];
      WIN_PRG0: bank = prg_bank[1];
      WIN_PRG1: bank = prg_bank[2];
      WIN_PRG2: bank = prg_bank[3];
      default:  bank = FIXED_BANK;
    endcase
  end

  always_comb begin
    bank_select_next  = bank_select;
    prg_bank_next     = prg_bank;
    chr_bank_next     = chr_bank;
    mirroring_next    = mirroring;
    irq_enabled_next  = irq_enabled;
    irq_counting_next = irq_counting;
    irq_count_next    = irq_count;
    irq_level_next    = irq_level;
    target            = TGT_NONE;
    mapped_address    = '0;

    case (item.action)
      ACT_TICK: begin
        if (irq_counting) begin
          irq_count_next = irq_count_dec;
          if (irq_count_dec == 16'hffff) irq_level_next = irq_enabled;
        end
      end
      ACT_READ: begin
        // Windows below the RAM window are open bus.
        if (win < WIN_RAM) begin
          target = TGT_OPEN;
        end else if (bank[6]) begin
          if (bank[7]) begin
            target         = TGT_RAM;
            mapped_address = {6'd0, item.address[12:0]};
          end else begin
            target = TGT_OPEN;
          end
        end else begin
          target         = TGT_ROM;
          mapped_address = {bank[5:0], item.address[12:0]};
        end
      end
      ACT_WRITE: begin
        if (win == WIN_RAM) begin
          target         = TGT_RAM;
          mapped_address = {6'd0, item.address[12:0]};
        end
        if (item.address == ADDR_BANK_SEL) bank_select_next = item.write_data[3:0];
        if (item.address == ADDR_BANK_DATA) begin
          if (!bank_select[3]) begin
            chr_bank_next[bank_select[2:0]] = item.write_data;
          end else begin
            case (bank_select)
              REG_MIRROR: mirroring_next = item.write_data[1:0];
              REG_IRQ_CTRL: begin
                irq_enabled_next  = item.write_data[7];
                irq_counting_next = item.write_data[0];
                if (!item.write_data[7]) irq_level_next = 1'b0;
              end
              REG_IRQ_LO: irq_count_next = {irq_count[15:8], item.write_data};
              REG_IRQ_HI: irq_count_next = {item.write_data, irq_count[7:0]};
              default:    prg_bank_next[bank_select[1:0]] = item.write_data;
            endcase
          end
        end
      end
      default: begin
        if (item.address[13]) begin
          target = TGT_NT;
          case (mirroring)
            MIR_VERT:   mapped_address = {8'd0, item.address[10:0]};
            MIR_HORZ:   mapped_address = {8'd0, item.address[11], item.address[9:0]};
            MIR_SCR_LO: mapped_address = {9'd0, item.address[9:0]};
            default:    mapped_address = {8'd0, 1'b1, item.address[9:0]};
          endcase
        end else begin
          target         = TGT_CHR;
          mapped_address = {1'b0, chr_bank[item.address[12:10]], item.address[9:0]};
        end
      end
    endcase
  end

  assign irq_next = irq_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select  <= '0;
      prg_bank     <= '{default: '0};
      chr_bank     <= '{default: '0};
      mirroring    <= '0;
      irq_enabled  <= 1'b0;
      irq_counting <= 1'b0;
      irq_count    <= '0;
      irq_level    <= 1'b0;
    end else if (op_valid) begin
      bank_select  <= bank_select_next;
      prg_bank     <= prg_bank_next;
      chr_bank     <= chr_bank_next;
      mirroring    <= mirroring_next;
      irq_enabled  <= irq_enabled_next;
      irq_counting <= irq_counting_next;
      irq_count    <= irq_count_next;
      irq_level    <= irq_level_next;
    end
  end

endmodule

`default_nettype wire

[design/cmtg_sound.sv]
`default_nettype none

module cmtg_sound
  import cmtg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         op_valid,
  input  wire item_t        item,
  output logic signed [15:0] audio_next
);

  logic [3:0]  sound_select, sound_select_next;
  logic [11:0] period [NUM_TONES];
  logic [11:0] period_next [NUM_TONES];
  logic        tone_off [NUM_TONES];
  logic        tone_off_next [NUM_TONES];
  logic [3:0]  volume [NUM_TONES];
  logic [3:0]  volume_next [NUM_TONES];
  logic [15:0] countdown [NUM_TONES];
  logic [15:0] countdown_next [NUM_TONES];
  logic        phase [NUM_TONES];
  logic        phase_next [NUM_TONES];
  logic [3:0]  level [NUM_TONES];
  logic [3:0]  level_next [NUM_TONES];

  logic        is_tick;
  logic        snd_write;
  logic [14:0] sum;

  assign is_tick   = (item.action == ACT_TICK);
  assign snd_write = (item.action == ACT_WRITE) && (item.address == ADDR_SOUND_DATA);

  // Channel clocking on a tick.
  always_comb begin
    logic [15:0] dec;
    for (int c = 0; c < NUM_TONES; c++) begin
      dec               = countdown[c] - 16'd1;
      countdown_next[c] = countdown[c];
      phase_next[c]     = phase[c];
      level_next[c]     = level[c];
      if (is_tick) begin
        countdown_next[c] = dec;
        if (dec == 16'd0) begin
          // A zero period reloads zero, so the next toggle is a full wrap away.
          countdown_next[c] = {period[c], 4'd0};
          phase_next[c]     = !phase[c];
        end
        level_next[c] = (phase_next[c] && !tone_off[c]) ? volume[c] : 4'd0;
      end
    end
  end

  // Register writes.
  always_comb begin
    sound_select_next = sound_select;
    period_next       = period;
    tone_off_next     = tone_off;
    volume_next       = volume;
    if ((item.action == ACT_WRITE) && (item.address == ADDR_SOUND_SEL)) begin
      sound_select_next = item.write_data[3:0];
    end
    if (snd_write) begin
      case (sound_select)
        SND_OFF: begin
          for (int c = 0; c < NUM_TONES; c++) tone_off_next[c] = item.write_data[c];
        end
        default: begin
          if (sound_select <= SND_PERIOD_LAST) begin
            if (sound_select[0]) begin
              period_next[sound_select[2:1]] =
                {item.write_data[3:0], period[sound_select[2:1]][7:0]};
            end else begin
              period_next[sound_select[2:1]] =
                {period[sound_select[2:1]][11:8], item.write_data};
            end
          end else if ((sound_select >= SND_VOL_FIRST) && (sound_select <= SND_VOL_LAST)) begin
            volume_next[sound_select[1:0]] = item.write_data[3:0];
          end
        end
      endcase
    end
  end

  assign sum = 15'({1'b0, atten(level_next[0])}) + 15'({1'b0, atten(level_next[1])})
             + 15'({1'b0, atten(level_next[2])});
  assign audio_next = 16'd0 - {1'b0, sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_select <= '0;
      period       <= '{default: 12'd1};
      tone_off     <= '{default: 1'b1};
      volume       <= '{default: '0};
      countdown    <= '{default: '0};
      phase        <= '{default: 1'b0};
      level        <= '{default: '0};
    end else if (op_valid) begin
      sound_select <= sound_select_next;
      period       <= period_next;
      tone_off     <= tone_off_next;
      volume       <= volume_next;
      countdown    <= countdown_next;
      phase        <= phase_next;
      level        <= level_next;
    end
  end

endmodule

`default_nettype wire

[design/cartridge_mapper_with_tone_generator_top.sv]
// Bank mapper with IRQ down-counter and three square tone channels. Every input
// beat (tick, CPU read, CPU write or PPU access) yields exactly one output beat
// carrying the target memory, the translated address, the IRQ line level and the
// audio sample after that beat. The block takes one beat per clock while the output
// is not stalled; a beat passes through the input register and then the result
// register, and the mapper and tone state is updated in the cycle an item moves
// from the input register to the result register. Output backpressure stalls the
// input register, which then drops s_axis_tready.
`default_nettype none
`include "cartridge_mapper_with_tone_generator_top_defines.svh"

module cartridge_mapper_with_tone_generator_top
  import cmtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // address[15:0], write_data[23:16]
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // mapped_address[18:0], irq_out[19],
                                          // audio_sample[35:20], zero[39:36]
  output logic [2:0]       m_axis_tuser   // target[2:0]
);

  logic        in_valid;
  item_t       in_item;
  logic        out_valid;
  logic        out_free;
  logic        op_valid;

  logic [2:0]        target;
  logic [18:0]       mapped_address;
  logic              irq_next;
  logic signed [15:0] audio_next;

  logic [2:0]        out_target;
  logic [18:0]       out_address;
  logic              out_irq;
  logic signed [15:0] out_audio;

  assign out_free      = !out_valid || m_axis_tready;
  assign op_valid      = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.action     <= s_axis_tuser;
      in_item.address    <= s_axis_tdata[15:0];
      in_item.write_data <= s_axis_tdata[23:16];
    end
  end

  cmtg_mapper u_mapper (
    .clk            (clk),
    .rst            (rst),
    .op_valid       (op_valid),
    .item           (in_item),
    .target         (target),
    .mapped_address (mapped_address),
    .irq_next       (irq_next)
  );

  cmtg_sound u_sound (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (op_valid),
    .item       (in_item),
    .audio_next (audio_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      out_target  <= target;
      out_address <= mapped_address;
      out_irq     <= irq_next;
      out_audio   <= audio_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_target;
  assign m_axis_tdata  = {4'd0, out_audio, out_irq, out_address};

  `CMTG_ASSERT_NEXT(a_in_held, clk, rst, in_valid && !out_free, in_valid,
    "stalled input item was dropped")
  `CMTG_ASSERT_NEXT(a_result_follows, clk, rst, op_valid, out_valid,
    "processed item produced no result")
  `CMTG_ASSERT_SAME(a_idle_addr_zero, clk, rst,
    out_valid && (out_target == TGT_OPEN || out_target == TGT_NONE),
    out_address == 19'd0, "open bus or no target with nonzero address")
  `CMTG_ASSERT_SAME(a_audio_nonpos, clk, rst, out_valid,
    out_audio[15] || (out_audio == 16'sd0), "audio sample is positive")

endmodule

`default_nettype wire

[tb/cartridge_mapper_with_tone_generator_top_tb.sv]
`timescale 1ns / 100ps

module cartridge_mapper_with_tone_generator_top_tb;
  import cmtg_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int RANDOM_ITEMS    = 1000;
  localparam int TONE_TICKS      = 48;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_PRINTED     = 64;

  // Bank register index that the package leaves unnamed.
  localparam logic [3:0] REG_PRG_FIRST = 4'd8;

  localparam logic [13:0] LEVEL_AMP [16] = '{
    14'd45,   14'd64,   14'd90,   14'd128,  14'd181,  14'd256,  14'd362,  14'd512,
    14'd724,  14'd1024, 14'd1448, 14'd2048, 14'd2896, 14'd4096, 14'd5792, 14'd8192
  };

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] maddr;
    logic        irq;
    logic [15:0] sample;
  } bus_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  cartridge_mapper_with_tone_generator_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mapper and tone state as the testbench sees it.
  logic [3:0]  map_bank_sel;
  logic [3:0]  map_sound_sel;
  logic [7:0]  prg_banks [4];
  logic [7:0]  chr_banks [8];
  logic [1:0]  nt_mirror;
  logic        irq_armed;
  logic        irq_running;
  logic [15:0] irq_count;
  logic        irq_line;
  logic [11:0] tone_div   [3];
  logic        tone_mute  [3];
  logic [3:0]  tone_vol   [3];
  logic [15:0] tone_timer [3];
  logic        tone_high  [3];
  logic [3:0]  tone_out   [3];

  bus_result_t pending_bus_results [$];
  int          error_count;
  int          cycle_count;
  bit          gaps_on;
  bit          sink_stalls_on;
  bit          hold_off_req;

  task automatic clear_mapper_state();
    map_bank_sel  = '0;
    map_sound_sel = '0;
    for (int i = 0; i < 4; i++) prg_banks[i] = '0;
    for (int i = 0; i < 8; i++) chr_banks[i] = '0;
    nt_mirror   = MIR_VERT;
    irq_armed   = 1'b0;
    irq_running = 1'b0;
    irq_count   = '0;
    irq_line    = 1'b0;
    for (int c = 0; c < NUM_TONES; c++) begin
      tone_div[c]   = 12'd1;
      tone_mute[c]  = 1'b1;
      tone_vol[c]   = '0;
      tone_timer[c] = '0;
      tone_high[c]  = 1'b0;
      tone_out[c]   = '0;
    end
  endtask

  // Applies one bus beat to the state above and forms the result it yields.
  task automatic map_bus_item(input item_t it, output bus_result_t res);
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  bank;
    int unsigned level_sum;
    int          c;
    a = it.address;
    d = it.write_data;
    res.target = TGT_NONE;
    res.maddr  = '0;
    case (it.action)
      ACT_TICK: begin
        if (irq_running) begin
          irq_count = irq_count - 16'd1;
          if (irq_count == 16'hffff) irq_line = irq_armed;
        end
        for (c = 0; c < NUM_TONES; c++) begin
          tone_timer[c] = tone_timer[c] - 16'd1;
          if (tone_timer[c] == 16'd0) begin
            tone_timer[c] = {tone_div[c], 4'b0000};
            tone_high[c]  = ~tone_high[c];
          end
          tone_out[c] = (tone_high[c] && !tone_mute[c]) ? tone_vol[c] : 4'd0;
        end
      end
      ACT_READ: begin
        if (a[15:13] < WIN_RAM) begin
          res.target = TGT_OPEN;
        end else begin
          case (a[15:13])
            WIN_RAM:  bank = prg_banks[0];
            WIN_PRG0: bank = prg_banks[1];
            WIN_PRG1: bank = prg_banks[2];
            WIN_PRG2: bank = prg_banks[3];
            default:  bank = FIXED_BANK;
          endcase
          if (bank[6]) begin
            if (bank[7]) begin
              res.target = TGT_RAM;
              res.maddr  = {6'd0, a[12:0]};
            end else begin
              res.target = TGT_OPEN;
            end
          end else begin
            res.target = TGT_ROM;
            res.maddr  = {bank[5:0], a[12:0]};
          end
        end
      end
      ACT_WRITE: begin
        // The RAM window takes the write no matter what the enable bit says.
        if (a[15:13] == WIN_RAM) begin
          res.target = TGT_RAM;
          res.maddr  = {6'd0, a[12:0]};
        end
        case (a)
          ADDR_BANK_SEL:  map_bank_sel = d[3:0];
          ADDR_SOUND_SEL: map_sound_sel = d[3:0];
          ADDR_BANK_DATA: begin
            if (map_bank_sel < REG_PRG_FIRST) begin
              chr_banks[map_bank_sel[2:0]] = d;
            end else if (map_bank_sel < REG_MIRROR) begin
              prg_banks[map_bank_sel[1:0]] = d;
            end else begin
              case (map_bank_sel)
                REG_MIRROR: nt_mirror = d[1:0];
                REG_IRQ_CTRL: begin
                  irq_armed   = d[7];
                  irq_running = d[0];
                  if (!d[7]) irq_line = 1'b0;
                end
                REG_IRQ_LO: irq_count[7:0] = d;
                default:    irq_count[15:8] = d;
              endcase
            end
          end
          ADDR_SOUND_DATA: begin
            if (map_sound_sel <= SND_PERIOD_LAST) begin
              c = map_sound_sel >> 1;
              if (map_sound_sel[0]) tone_div[c][11:8] = d[3:0];
              else tone_div[c][7:0] = d;
            end else if (map_sound_sel == SND_OFF) begin
              for (c = 0; c < NUM_TONES; c++) tone_mute[c] = d[c];
            end else if (map_sound_sel >= SND_VOL_FIRST && map_sound_sel <= SND_VOL_LAST) begin
              tone_vol[map_sound_sel - SND_VOL_FIRST] = d[3:0];
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (a[13]) begin
          res.target = TGT_NT;
          case (nt_mirror)
            MIR_VERT:   res.maddr = {8'd0, a[10:0]};
            MIR_HORZ:   res.maddr = {8'd0, a[11], a[9:0]};
            MIR_SCR_LO: res.maddr = {9'd0, a[9:0]};
            default:    res.maddr = {8'd0, 1'b1, a[9:0]};
          endcase
        end else begin
          res.target = TGT_CHR;
          res.maddr  = {1'b0, chr_banks[a[12:10]], a[9:0]};
        end
      end
    endcase
    level_sum = 0;
    for (c = 0; c < NUM_TONES; c++) level_sum += LEVEL_AMP[tone_out[c]];
    res.irq    = irq_line;
    res.sample = 16'(0 - level_sum);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTED)
      $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
               what, cycle_count, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic [1:0] act, input logic [15:0] addr,
                           input logic [7:0] wdata);
    item_t       beat;
    bus_result_t want;
    int          gap;
    gap = gaps_on ? $urandom_range(16) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.action     = act;
    beat.address    = addr;
    beat.write_data = wdata;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {beat.write_data, beat.address};
    s_axis_tuser  <= beat.action;
    do @(posedge clk); while (!s_axis_tready);
    map_bus_item(beat, want);
    pending_bus_results.push_back(want);
  endtask

  // Select port first, then data port; the unused select bits carry noise.
  task automatic set_indexed(input logic [15:0] sel_port, input logic [3:0] idx,
                             input logic [7:0] val);
    send_item(ACT_WRITE, sel_port, {4'($urandom), idx});
    send_item(ACT_WRITE, sel_port + 16'h2000, val);
  endtask

  task automatic test_power_on_map();
    send_item(ACT_READ, 16'h0000, 8'h00);
    send_item(ACT_READ, 16'h5fff, 8'hff);
    send_item(ACT_READ, 16'h6000, 8'h00);
    send_item(ACT_READ, 16'hffff, 8'h00);
    send_item(ACT_PPU, 16'h0000, 8'h00);
    send_item(ACT_PPU, 16'hffff, 8'hff);
    send_item(ACT_TICK, 16'hffff, 8'hff);
  endtask

  task automatic test_bank_registers();
    set_indexed(ADDR_BANK_SEL, REG_PRG_FIRST, 8'hc0);
    send_item(ACT_READ, 16'h7abc, 8'h00);
    set_indexed(ADDR_BANK_SEL, REG_PRG_FIRST + 4'd1, 8'h40);
    send_item(ACT_READ, 16'h9234, 8'h00);
    set_indexed(ADDR_BANK_SEL, 4'd7, 8'hff);
    send_item(ACT_PPU, 16'h1fff, 8'h00);
    set_indexed(ADDR_BANK_SEL, REG_MIRROR, 8'hff);
    send_item(ACT_PPU, 16'h2c00, 8'h00);
    set_indexed(ADDR_BANK_SEL, REG_MIRROR, {6'd0, MIR_HORZ});
    send_item(ACT_PPU, 16'h2c00, 8'h00);
    send_item(ACT_WRITE, 16'h7fff, 8'h5a);
    send_item(ACT_WRITE, 16'h8001, 8'h0c);
    send_item(ACT_WRITE, 16'he001, 8'hff);
  endtask

  task automatic test_irq_counter();
    set_indexed(ADDR_BANK_SEL, REG_IRQ_LO, 8'h01);
    set_indexed(ADDR_BANK_SEL, REG_IRQ_HI, 8'h00);
    set_indexed(ADDR_BANK_SEL, REG_IRQ_CTRL, 8'h81);
    repeat (3) send_item(ACT_TICK, 16'h0000, 8'h00);
    // Clearing the enable drops the line while counting goes on.
    set_indexed(ADDR_BANK_SEL, REG_IRQ_CTRL, 8'h01);
    send_item(ACT_TICK, 16'h0000, 8'h00);
  endtask

  // The tone timers start at zero and need a full 16-bit wrap before the first
  // toggle, so this burst of ticks checks that the channels stay at the floor level.
  task automatic test_tone_channels();
    set_indexed(ADDR_SOUND_SEL, SND_VOL_FIRST, 8'h0f);
    set_indexed(ADDR_SOUND_SEL, SND_VOL_FIRST + 4'd1, 8'h08);
    set_indexed(ADDR_SOUND_SEL, SND_VOL_LAST, 8'hf3);
    set_indexed(ADDR_SOUND_SEL, SND_OFF, 8'hf8);
    set_indexed(ADDR_SOUND_SEL, 4'd0, 8'h01);
    set_indexed(ADDR_SOUND_SEL, 4'd2, 8'h02);
    set_indexed(ADDR_SOUND_SEL, 4'd4, 8'h00);
    set_indexed(ADDR_SOUND_SEL, SND_PERIOD_LAST, 8'hf0);
    set_indexed(ADDR_SOUND_SEL, 4'd6, 8'hff);
    set_indexed(ADDR_SOUND_SEL, 4'd15, 8'hff);
    set_indexed(ADDR_BANK_SEL, REG_IRQ_HI, 8'h40);
    set_indexed(ADDR_BANK_SEL, REG_IRQ_CTRL, 8'h81);
    gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (TONE_TICKS) send_item(ACT_TICK, 16'($urandom), 8'($urandom));
    gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic test_output_hold();
    gaps_on = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_item(2'($urandom_range(1) ? ACT_TICK : ACT_PPU), 16'($urandom),
                          8'($urandom));
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          sent;
    int          phase_left;
    int          pick;
    logic [3:0]  sel;
    logic [7:0]  val;
    logic [15:0] addr;
    sent = 0;
    phase_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        gaps_on = ($urandom_range(3) != 0);
        sink_stalls_on = ($urandom_range(3) != 0);
        phase_left = $urandom_range(150, 50);
      end
      pick = $urandom_range(99);
      val = 8'($urandom);
      if (pick < 30) begin
        send_item(ACT_TICK, 16'($urandom), val);
        sent += 1;
      end else if (pick < 45) begin
        send_item(ACT_READ, 16'($urandom), val);
        sent += 1;
      end else if (pick < 60) begin
        send_item(ACT_PPU, 16'($urandom), val);
        sent += 1;
      end else if (pick < 78) begin
        // Bias the IRQ counter toward small values so that it wraps often.
        sel = 4'($urandom);
        if (sel == REG_IRQ_HI && $urandom_range(1)) val = 8'h00;
        if (sel == REG_IRQ_LO && $urandom_range(1)) val = 8'($urandom_range(40));
        set_indexed(ADDR_BANK_SEL, sel, val);
        sent += 2;
      end else if (pick < 92) begin
        sel = $urandom_range(1) ? 4'($urandom) : 4'($urandom_range(SND_VOL_LAST, SND_OFF));
        if (sel <= SND_PERIOD_LAST && sel[0] && $urandom_range(3) != 0) val[3:0] = 4'd0;
        if (sel <= SND_PERIOD_LAST && !sel[0] && $urandom_range(1)) val = 8'($urandom_range(3));
        set_indexed(ADDR_SOUND_SEL, sel, val);
        sent += 2;
      end else begin
        case ($urandom_range(2))
          0: addr = 16'($urandom);
          1: addr = {WIN_RAM, 13'($urandom)};
          default: addr = {3'($urandom_range(7, 4)), 13'($urandom_range(8191, 1))};
        endcase
        send_item(ACT_WRITE, addr, val);
        sent += 1;
      end
      phase_left--;
    end
  endtask

  always @(posedge clk) begin
    bus_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bus_results.size() == 0) begin
        report_mismatch("unexpected beat, target", 32'(m_axis_tuser), 32'd0);
      end else begin
        want = pending_bus_results.pop_front();
        if (m_axis_tuser !== want.target)
          report_mismatch("target", 32'(m_axis_tuser), 32'(want.target));
        if (m_axis_tdata[18:0] !== want.maddr)
          report_mismatch("mapped_address", 32'(m_axis_tdata[18:0]), 32'(want.maddr));
        if (m_axis_tdata[19] !== want.irq)
          report_mismatch("irq_out", 32'(m_axis_tdata[19]), 32'(want.irq));
        if (m_axis_tdata[35:20] !== want.sample)
          report_mismatch("audio_sample", 32'(m_axis_tdata[35:20]), 32'(want.sample));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: a random stall before each beat while stalls are on, or one long hold on request.
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end else begin
        hold = sink_stalls_on ? $urandom_range(16) : 0;
      end
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ACT_TICK;
    error_count    = 0;
    cycle_count    = 0;
    gaps_on        = 1'b1;
    sink_stalls_on = 1'b1;
    hold_off_req   = 1'b0;
    clear_mapper_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_power_on_map();
    test_bank_registers();
    test_irq_counter();
    test_tone_channels();
    test_output_hold();
    test_random_traffic();

    s_axis_tvalid <= 1'b0;
    while (pending_bus_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
